[hdl/worst_fit_allocator_coalescing_assert.svh]
// Assertion macros shared by the allocator RTL.
`ifndef WORST_FIT_ALLOCATOR_COALESCING_ASSERT_SVH
`define WORST_FIT_ALLOCATOR_COALESCING_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define WFAC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define WFAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFAC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wfac_pkg.sv]
// Types and constants of the worst-fit allocator.
package wfac_pkg;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BLKRD,
    S_SCAN,
    S_ALLOC,
    S_RELNXT,
    S_RELMRG,
    S_RESULT
  } state_t;

  typedef logic [1:0] status_t;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_NOFIT = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic REG_MEMORY_SIZE = 1'b0;

endpackage

[hdl/wfac_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
module wfac_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/worst_fit_allocator_coalescing.sv]
// Top level of the worst-fit allocator with coalescing of freed blocks.
//
// Items arrive on the in_ stream: in_tuser holds the action (allocate or free),
// in_tdata the block size and the number of an earlier request to free.
// Every allocate gives one result item on the out_ stream with a status in
// out_tuser and the 1-based start address in out_tdata; a free gives none.
// One item is worked on at a time. An allocate that fits walks the segment
// table in S_SCAN, takes its block in S_ALLOC and passes S_RESULT; one that
// finds no large enough segment goes from S_SCAN to S_RESULT, and one refused
// at once (tables full or zero size) goes straight to S_RESULT. A free of a
// live block reads its entry in S_BLKRD, walks the segment table in S_SCAN and
// merges in S_RELNXT and S_RELMRG before idle; a free of a request without a
// live block goes back to idle from S_BLKRD, and a free with an unusable
// number stays in idle. The next item is taken once idle is reached. The walk
// over the segment table reads one entry per cycle. After reset, and after
// every write of memory_size, a clearing pass over all MAX_SEGMENTS entries
// rebuilds the segment table while in_tready stays low; request numbering
// restarts from 1. The result sits in an output register, so a new item is
// accepted while the receiver stalls; a later result waits until it is taken.
module worst_fit_allocator_coalescing #(
  parameter int MAX_REQUESTS = 65536,
  parameter int MAX_SEGMENTS = 1024,
  parameter int ADDR_BITS    = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // block_size [31:0], request_number [48:32]
  input  logic [0:0]  in_tuser,   // action [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // address [31:0]
  output logic [1:0]  out_tuser,  // status [1:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SW   = ADDR_BITS + 1;
  localparam int VW   = (SW > 32) ? SW : 32;
  localparam int RIW  = $clog2(MAX_REQUESTS);
  localparam int RCW  = $clog2(MAX_REQUESTS + 1);
  localparam int NW   = (RCW > 17) ? RCW : 17;
  localparam int SIW  = $clog2(MAX_SEGMENTS);
  localparam int SCW  = $clog2(MAX_SEGMENTS + 1);
  localparam int EW   = 1 + 2 * SW;

  wfac_pkg::state_t    state_r, state_nxt;
  logic [31:0]         mem_size_r, mem_size_nxt;
  logic [SIW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [RCW-1:0]      req_cnt_r, req_cnt_nxt;
  logic [SIW-1:0]      live_r, live_nxt;
  logic                act_r, act_nxt;
  logic [31:0]         want_r, want_nxt;
  logic [RIW-1:0]      slot_r, slot_nxt;
  logic [RIW-1:0]      rel_idx_r, rel_idx_nxt;
  logic [SCW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic                found_r, found_nxt;
  logic [SIW-1:0]      best_idx_r, best_idx_nxt;
  logic [SW-1:0]       best_st_r, best_st_nxt;
  logic [SW-1:0]       best_sz_r, best_sz_nxt;
  logic                prv_ok_r, prv_ok_nxt;
  logic [SIW-1:0]      prv_idx_r, prv_idx_nxt;
  logic [SW-1:0]       prv_st_r, prv_st_nxt;
  logic [SW-1:0]       prv_sz_r, prv_sz_nxt;
  logic                nxt_ok_r, nxt_ok_nxt;
  logic [SIW-1:0]      nxt_idx_r, nxt_idx_nxt;
  logic [SW-1:0]       nxt_sz_r, nxt_sz_nxt;
  logic                emp_ok_r, emp_ok_nxt;
  logic [SIW-1:0]      emp_idx_r, emp_idx_nxt;
  logic [SW-1:0]       b_r, b_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  wfac_pkg::status_t   pst_r, pst_nxt;
  logic [31:0]         pad_r, pad_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  wfac_pkg::status_t   out_st_r, out_st_nxt;
  logic [31:0]         out_ad_r, out_ad_nxt;

  logic                seg_we;
  logic [SIW-1:0]      seg_waddr, seg_raddr;
  logic [EW-1:0]       seg_wdata, seg_rdata;
  logic                blk_we;
  logic [RIW-1:0]      blk_waddr, blk_raddr;
  logic [EW-1:0]       blk_wdata, blk_rdata;

  logic                cfg_wr;
  logic                alloc_wr;
  logic                alloc_acc;
  logic [SW-1:0]       cap_sz;
  logic [VW-1:0]       ms_v, lim_v;

  wfac_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_seg_ram (
    .clk(clk), .we(seg_we), .waddr(seg_waddr), .wdata(seg_wdata),
    .raddr(seg_raddr), .rdata(seg_rdata)
  );

  wfac_ram #(.DEPTH(MAX_REQUESTS), .WIDTH(EW)) u_blk_ram (
    .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
    .raddr(blk_raddr), .rdata(blk_rdata)
  );

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == wfac_pkg::REG_MEMORY_SIZE) ? mem_size_r : 32'd0;

  assign alloc_wr  = (state_r == wfac_pkg::S_ALLOC) && !cfg_wr;
  assign alloc_acc = in_tvalid && in_tready && (in_tuser[0] == wfac_pkg::ACT_ALLOC);

  assign ms_v   = VW'(mem_size_r);
  assign lim_v  = VW'(1) << ADDR_BITS;
  assign cap_sz = SW'((ms_v > lim_v) ? lim_v : ms_v);

  assign in_tready  = (state_r == wfac_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_ad_r;
  assign out_tuser  = out_st_r;

  always_comb begin
    logic          e_v;
    logic [SW-1:0] e_st, e_sz;
    logic [SIW-1:0] e_idx;
    logic [16:0]   rnum;
    logic          slot_ok;
    logic [SW-1:0] rem_sz;
    logic [VW-1:0] addr_v;

    state_nxt    = state_r;
    mem_size_nxt = mem_size_r;
    clr_idx_nxt  = clr_idx_r;
    req_cnt_nxt  = req_cnt_r;
    live_nxt     = live_r;
    act_nxt      = act_r;
    want_nxt     = want_r;
    slot_nxt     = slot_r;
    rel_idx_nxt  = rel_idx_r;
    scan_cnt_nxt = scan_cnt_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_st_nxt  = best_st_r;
    best_sz_nxt  = best_sz_r;
    prv_ok_nxt   = prv_ok_r;
    prv_idx_nxt  = prv_idx_r;
    prv_st_nxt   = prv_st_r;
    prv_sz_nxt   = prv_sz_r;
    nxt_ok_nxt   = nxt_ok_r;
    nxt_idx_nxt  = nxt_idx_r;
    nxt_sz_nxt   = nxt_sz_r;
    emp_ok_nxt   = emp_ok_r;
    emp_idx_nxt  = emp_idx_r;
    b_nxt        = b_r;
    s_nxt        = s_r;
    pst_nxt      = pst_r;
    pad_nxt      = pad_r;
    out_tvalid_nxt = out_tvalid_r;
    out_st_nxt   = out_st_r;
    out_ad_nxt   = out_ad_r;

    seg_we    = 1'b0;
    seg_waddr = '0;
    seg_wdata = '0;
    seg_raddr = scan_cnt_r[SIW-1:0];
    blk_we    = 1'b0;
    blk_waddr = slot_r;
    blk_wdata = '0;
    blk_raddr = rel_idx_r;

    e_v    = seg_rdata[EW-1];
    e_st   = seg_rdata[2*SW-1:SW];
    e_sz   = seg_rdata[SW-1:0];
    e_idx  = SIW'(scan_cnt_r - SCW'(1));
    rnum   = in_tdata[48:32];
    slot_ok = (req_cnt_r < RCW'(MAX_REQUESTS));
    rem_sz = best_sz_r - SW'(want_r);
    addr_v = VW'(best_st_r + SW'(1));

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      wfac_pkg::S_CLEAR: begin
        seg_we    = 1'b1;
        seg_waddr = clr_idx_r;
        if (clr_idx_r == '0) begin
          seg_wdata = {(cap_sz != '0), {SW{1'b0}}, cap_sz};
        end
        clr_idx_nxt = clr_idx_r + SIW'(1);
        if (clr_idx_r == SIW'(MAX_SEGMENTS - 1)) begin
          state_nxt = wfac_pkg::S_IDLE;
        end
      end
      wfac_pkg::S_IDLE: begin
        if (in_tvalid) begin
          act_nxt  = in_tuser[0];
          want_nxt = in_tdata[31:0];
          slot_nxt = req_cnt_r[RIW-1:0];
          if (slot_ok) begin
            req_cnt_nxt = req_cnt_r + RCW'(1);
            blk_we      = 1'b1;
            blk_waddr   = req_cnt_r[RIW-1:0];
          end
          scan_cnt_nxt = '0;
          found_nxt    = 1'b0;
          prv_ok_nxt   = 1'b0;
          nxt_ok_nxt   = 1'b0;
          emp_ok_nxt   = 1'b0;
          if (in_tuser[0] == wfac_pkg::ACT_FREE) begin
            rel_idx_nxt = RIW'(rnum - 17'd1);
            blk_raddr   = RIW'(rnum - 17'd1);
            if (rnum != '0 && NW'(rnum) <= NW'(req_cnt_r)) begin
              state_nxt = wfac_pkg::S_BLKRD;
            end
          end else if (!slot_ok || live_r == SIW'(MAX_SEGMENTS - 1)) begin
            pst_nxt   = wfac_pkg::STAT_FULL;
            pad_nxt   = '0;
            state_nxt = wfac_pkg::S_RESULT;
          end else if (in_tdata[31:0] == '0) begin
            pst_nxt   = wfac_pkg::STAT_NOFIT;
            pad_nxt   = '0;
            state_nxt = wfac_pkg::S_RESULT;
          end else begin
            state_nxt = wfac_pkg::S_SCAN;
          end
        end
      end
      wfac_pkg::S_BLKRD: begin
        b_nxt = blk_rdata[2*SW-1:SW];
        s_nxt = blk_rdata[SW-1:0];
        state_nxt = blk_rdata[EW-1] ? wfac_pkg::S_SCAN : wfac_pkg::S_IDLE;
      end
      wfac_pkg::S_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + SCW'(1);
        if (scan_cnt_r != '0) begin
          if (act_r == wfac_pkg::ACT_ALLOC) begin
            if (e_v && (!found_r || e_sz > best_sz_r ||
                (e_sz == best_sz_r && e_st < best_st_r))) begin
              found_nxt    = 1'b1;
              best_idx_nxt = e_idx;
              best_st_nxt  = e_st;
              best_sz_nxt  = e_sz;
            end
          end else if (!e_v) begin
            if (!emp_ok_r) begin
              emp_ok_nxt  = 1'b1;
              emp_idx_nxt = e_idx;
            end
          end else if (e_st + e_sz == b_r) begin
            prv_ok_nxt  = 1'b1;
            prv_idx_nxt = e_idx;
            prv_st_nxt  = e_st;
            prv_sz_nxt  = e_sz;
          end else if (e_st == b_r + s_r) begin
            nxt_ok_nxt  = 1'b1;
            nxt_idx_nxt = e_idx;
            nxt_sz_nxt  = e_sz;
          end
        end
        if (scan_cnt_r == SCW'(MAX_SEGMENTS)) begin
          if (act_r == wfac_pkg::ACT_FREE) begin
            state_nxt = wfac_pkg::S_RELNXT;
          end else if (found_nxt && VW'(best_sz_nxt) >= VW'(want_r)) begin
            state_nxt = wfac_pkg::S_ALLOC;
          end else begin
            pst_nxt   = wfac_pkg::STAT_NOFIT;
            pad_nxt   = '0;
            state_nxt = wfac_pkg::S_RESULT;
          end
        end
      end
      wfac_pkg::S_ALLOC: begin
        seg_we    = 1'b1;
        seg_waddr = best_idx_r;
        if (rem_sz != '0) begin
          seg_wdata = {1'b1, best_st_r + SW'(want_r), rem_sz};
        end
        blk_we    = 1'b1;
        blk_waddr = slot_r;
        blk_wdata = {1'b1, best_st_r, SW'(want_r)};
        live_nxt  = live_r + SIW'(1);
        pst_nxt   = wfac_pkg::STAT_OK;
        pad_nxt   = addr_v[31:0];
        state_nxt = wfac_pkg::S_RESULT;
      end
      wfac_pkg::S_RELNXT: begin
        blk_we    = 1'b1;
        blk_waddr = rel_idx_r;
        if (live_r != '0) begin
          live_nxt = live_r - SIW'(1);
        end
        if (nxt_ok_r) begin
          seg_we    = 1'b1;
          seg_waddr = nxt_idx_r;
          s_nxt     = s_r + nxt_sz_r;
          if (!emp_ok_r || nxt_idx_r < emp_idx_r) begin
            emp_ok_nxt  = 1'b1;
            emp_idx_nxt = nxt_idx_r;
          end
        end
        state_nxt = wfac_pkg::S_RELMRG;
      end
      wfac_pkg::S_RELMRG: begin
        if (prv_ok_r) begin
          seg_we    = 1'b1;
          seg_waddr = prv_idx_r;
          seg_wdata = {1'b1, prv_st_r, prv_sz_r + s_r};
        end else if (emp_ok_r) begin
          seg_we    = 1'b1;
          seg_waddr = emp_idx_r;
          seg_wdata = {1'b1, b_r, s_r};
        end
        state_nxt = wfac_pkg::S_IDLE;
      end
      wfac_pkg::S_RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_st_nxt     = pst_r;
          out_ad_nxt     = pad_r;
          state_nxt      = wfac_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wfac_pkg::S_CLEAR;
      end
    endcase

    if (cfg_wr && cfg_paddr[2] == wfac_pkg::REG_MEMORY_SIZE) begin
      mem_size_nxt = cfg_pwdata;
      state_nxt    = wfac_pkg::S_CLEAR;
      clr_idx_nxt  = '0;
      req_cnt_nxt  = '0;
      live_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wfac_pkg::S_CLEAR;
      mem_size_r   <= 32'h8000_0000;
      clr_idx_r    <= '0;
      req_cnt_r    <= '0;
      live_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mem_size_r   <= mem_size_nxt;
      clr_idx_r    <= clr_idx_nxt;
      req_cnt_r    <= req_cnt_nxt;
      live_r       <= live_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    want_r     <= want_nxt;
    slot_r     <= slot_nxt;
    rel_idx_r  <= rel_idx_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    found_r    <= found_nxt;
    best_idx_r <= best_idx_nxt;
    best_st_r  <= best_st_nxt;
    best_sz_r  <= best_sz_nxt;
    prv_ok_r   <= prv_ok_nxt;
    prv_idx_r  <= prv_idx_nxt;
    prv_st_r   <= prv_st_nxt;
    prv_sz_r   <= prv_sz_nxt;
    nxt_ok_r   <= nxt_ok_nxt;
    nxt_idx_r  <= nxt_idx_nxt;
    nxt_sz_r   <= nxt_sz_nxt;
    emp_ok_r   <= emp_ok_nxt;
    emp_idx_r  <= emp_idx_nxt;
    b_r        <= b_nxt;
    s_r        <= s_nxt;
    pst_r      <= pst_nxt;
    pad_r      <= pad_nxt;
    out_st_r   <= out_st_nxt;
    out_ad_r   <= out_ad_nxt;
  end

`include "worst_fit_allocator_coalescing_assert.svh"

  `WFAC_ASSERT_NXT(a_one_item, alloc_acc, !in_tready, "item accepted while busy")
  `WFAC_ASSERT_ALWAYS(a_req_cnt, req_cnt_r <= RCW'(MAX_REQUESTS), "request count overflow")
  `WFAC_ASSERT_NXT(a_live_inc, alloc_wr, live_r == $past(live_r) + SIW'(1), "live count not raised")
  `WFAC_ASSERT_IMP(a_out_src, $rose(out_tvalid_r), $past(state_r) == wfac_pkg::S_RESULT, "result without allocate")

endmodule

[tb/sv/wfac_checker.sv]
// Checker for the worst-fit allocator: predicts each result item and compares it.
module wfac_checker #(
  parameter int MAX_REQUESTS = 65536,
  parameter int MAX_SEGMENTS = 1024,
  parameter int ADDR_BITS    = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    wfac_pkg::status_t status;
    logic [31:0]       address;
  } alloc_result_t;

  alloc_result_t     expected_results[$];
  longint unsigned   mem_cells;
  bit                blk_live[MAX_REQUESTS];
  longint unsigned   blk_base[MAX_REQUESTS];
  longint unsigned   blk_len[MAX_REQUESTS];
  bit                seg_used[MAX_SEGMENTS];
  longint unsigned   seg_base[MAX_SEGMENTS];
  longint unsigned   seg_len[MAX_SEGMENTS];
  longint unsigned   req_count;
  longint unsigned   live_count;

  task automatic rebuild_heap();
    longint unsigned cap;
    cap = longint'(1) << ADDR_BITS;
    for (int i = 0; i < MAX_REQUESTS; i++) begin
      blk_live[i] = 0;
      blk_base[i] = 0;
      blk_len[i]  = 0;
    end
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      seg_used[i] = 0;
      seg_base[i] = 0;
      seg_len[i]  = 0;
    end
    if (mem_cells > cap) cap = cap; else cap = mem_cells;
    if (cap != 0) begin
      seg_used[0] = 1;
      seg_len[0]  = cap;
    end
    req_count  = 0;
    live_count = 0;
  endtask

  task automatic return_block(longint unsigned slot);
    longint unsigned b, s, e;
    int prv, nxt, hole;
    b = blk_base[slot];
    s = blk_len[slot];
    e = b + s;
    prv = -1;
    nxt = -1;
    hole = -1;
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      if (!seg_used[k]) begin
        if (hole < 0) hole = k;
      end else if (seg_base[k] + seg_len[k] == b) begin
        prv = k;
      end else if (seg_base[k] == e) begin
        nxt = k;
      end
    end
    blk_live[slot] = 0;
    blk_base[slot] = 0;
    blk_len[slot]  = 0;
    if (live_count > 0) live_count--;
    if (nxt >= 0) begin
      s += seg_len[nxt];
      seg_used[nxt] = 0;
      seg_base[nxt] = 0;
      seg_len[nxt]  = 0;
      if (hole < 0 || nxt < hole) hole = nxt;
    end
    if (prv >= 0) begin
      seg_len[prv] += s;
    end else if (hole >= 0) begin
      seg_used[hole] = 1;
      seg_base[hole] = b;
      seg_len[hole]  = s;
    end
  endtask

  task automatic serve_request(logic act, longint unsigned want, longint unsigned rnum);
    longint unsigned slot;
    int best;
    alloc_result_t res;
    slot = req_count;
    best = -1;
    if (req_count < MAX_REQUESTS) req_count++;
    if (act == wfac_pkg::ACT_FREE) begin
      if (rnum >= 1 && rnum - 1 < slot && blk_live[rnum-1]) return_block(rnum - 1);
      return;
    end
    res.status  = wfac_pkg::STAT_OK;
    res.address = '0;
    if (slot >= MAX_REQUESTS || live_count >= MAX_SEGMENTS - 1) begin
      res.status = wfac_pkg::STAT_FULL;
    end else if (want == 0) begin
      res.status = wfac_pkg::STAT_NOFIT;
    end else begin
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
        if (!seg_used[k]) continue;
        if (best < 0 || seg_len[k] > seg_len[best] ||
            (seg_len[k] == seg_len[best] && seg_base[k] < seg_base[best])) best = k;
      end
      if (best < 0 || seg_len[best] < want) begin
        res.status = wfac_pkg::STAT_NOFIT;
      end else begin
        blk_live[slot] = 1;
        blk_base[slot] = seg_base[best];
        blk_len[slot]  = want;
        live_count++;
        res.address = 32'(seg_base[best] + 1);
        seg_base[best] += want;
        seg_len[best]  -= want;
        if (seg_len[best] == 0) begin
          seg_used[best] = 0;
          seg_base[best] = 0;
        end
      end
    end
    expected_results = {expected_results, res};
  endtask

  initial begin
    fails = 0;
    pending = 0;
    mem_cells = 64'd2147483648;
    rebuild_heap();
  end

  always @(posedge clk) begin
    alloc_result_t exp_res;
    if (!rst_n) begin
      mem_cells = 64'd2147483648;
      rebuild_heap();
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: status %0d address %0d", out_tuser, out_tdata);
          fails++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_tuser !== exp_res.status) begin
            $error("status mismatch: expected %0d actual %0d", exp_res.status, out_tuser);
            fails++;
          end
          if (out_tdata !== exp_res.address) begin
            $error("address mismatch: expected %0d actual %0d", exp_res.address, out_tdata);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready)
        serve_request(in_tuser[0], in_tdata[31:0], in_tdata[48:32]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {wfac_pkg::REG_MEMORY_SIZE, 2'b00}) begin
        mem_cells = cfg_pwdata;
        rebuild_heap();
      end
    end
    pending = expected_results.size();
  end
endmodule

[tb/sv/tb_top.sv]
// Top of the allocator testbench: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  MAX_SEGMENTS = 1024;
  localparam int  SETTLE       = MAX_SEGMENTS + 64;
  localparam longint LIMIT     = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // block_size [31:0], request_number [48:32]
  logic [0:0]  in_tuser;   // action [0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // address [31:0]
  logic [1:0]  out_tuser;  // status [1:0]
  logic        cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  int          fails, pending;
  longint      cycles;
  int          hold_off;
  bit          busy_mode;
  longint unsigned mem_now;
  int          req_num;

  worst_fit_allocator_coalescing u_dut (.*);

  wfac_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    int g;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_tready <= 0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      g = pick_gap();
      if (g == 0) begin
        out_tready <= 1;
      end else begin
        out_tready <= 0;
        repeat (g - 1) @(posedge clk);
      end
    end
  end

  task automatic send_item(logic act, logic [31:0] want, logic [16:0] rnum);
    int g;
    in_tvalid <= 1;
    in_tuser  <= act;
    in_tdata  <= {7'd0, rnum, want};
    do @(posedge clk); while (!in_tready);
    req_num++;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g - 1) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(logic [31:0] value);
    cfg_psel    <= 1;
    cfg_pwrite  <= 1;
    cfg_paddr   <= {wfac_pkg::REG_MEMORY_SIZE, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel    <= 0;
    cfg_penable <= 0;
    cfg_pwrite  <= 0;
    mem_now = value;
    req_num = 0;
  endtask

  task automatic random_item();
    int r;
    longint unsigned cap;
    logic [31:0] want;
    logic [16:0] rnum;
    cap = (mem_now == 0) ? 1 : (mem_now > 64'h80000000 ? 64'h80000000 : mem_now);
    r = $urandom_range(0, 99);
    if (r < 55) begin
      want = (cap / 4 > 1) ? $urandom_range(1, 32'(cap / 4)) : 1;
      send_item(wfac_pkg::ACT_ALLOC, want, 17'($urandom));
    end else if (r < 62) begin
      want = (r < 60) ? $urandom_range(1, 32'(cap)) : $urandom;
      send_item(wfac_pkg::ACT_ALLOC, want, 17'($urandom));
    end else if (r < 94) begin
      rnum = (req_num > 0) ? 17'($urandom_range(1, req_num)) : 17'd1;
      send_item(wfac_pkg::ACT_FREE, $urandom, rnum);
    end else begin
      send_item(wfac_pkg::ACT_FREE, $urandom, (r < 97) ? 17'd0 : 17'($urandom));
    end
  endtask

  initial begin
    logic [31:0] sizes[$];
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    hold_off = 0; busy_mode = 0; mem_now = 64'h80000000; req_num = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;

    send_item(wfac_pkg::ACT_ALLOC, 32'h80000000, 17'd0);
    send_item(wfac_pkg::ACT_ALLOC, 32'd1, 17'd0);
    send_item(wfac_pkg::ACT_FREE, 32'hFFFFFFFF, 17'd1);
    send_item(wfac_pkg::ACT_ALLOC, 32'd0, 17'h1FFFF);
    send_item(wfac_pkg::ACT_FREE, 32'd0, 17'd0);
    send_item(wfac_pkg::ACT_FREE, 32'd0, 17'd9);
    send_item(wfac_pkg::ACT_FREE, 32'd0, 17'd2);
    send_item(wfac_pkg::ACT_ALLOC, 32'd1, 17'd0);
    send_item(wfac_pkg::ACT_ALLOC, 32'h7FFFFFFF, 17'd0);
    send_item(wfac_pkg::ACT_FREE, 32'd0, 17'd8);
    send_item(wfac_pkg::ACT_FREE, 32'd0, 17'd8);
    send_item(wfac_pkg::ACT_ALLOC, 32'hFFFFFFFF, 17'd0);
    send_item(wfac_pkg::ACT_ALLOC, 32'd16, 17'd0);
    send_item(wfac_pkg::ACT_FREE, 32'd0, 17'h1FFFF);
    send_item(wfac_pkg::ACT_FREE, 32'd0, 17'd13);
    send_item(wfac_pkg::ACT_ALLOC, 32'h80000000, 17'd0);
    drain();

    sizes = '{32'd0, 32'd1, 32'hFFFFFFFF, 32'd40, 32'd1000, 32'd4096,
              32'($urandom_range(8, 300)), 32'($urandom_range(300, 100000))};
    foreach (sizes[p]) begin
      write_size(sizes[p]);
      busy_mode = (p % 3 == 2);
      repeat (p < 3 ? 8 : 100) random_item();
      if (p == 4) begin
        hold_off = 3000;
        repeat (12) random_item();
        drain();
        repeat (20) random_item();
      end
      drain();
    end

    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hdl
hdl/wfac_pkg.sv
hdl/wfac_ram.sv
hdl/worst_fit_allocator_coalescing.sv
tb/sv/wfac_checker.sv
tb/sv/tb_top.sv
